// File: rtl/lobm_pkg.sv
// Package: shared types, codes and sizes of the limit order book matcher.
`default_nettype none
package lobm_pkg;

  localparam int BOOK_SLOTS = 32;
  localparam int SLOT_W     = $clog2(BOOK_SLOTS);
  localparam int CNT_W      = $clog2(BOOK_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NO_CROSS  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic TYPE_FAK    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_TRADE,
    S_REST,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic [63:0]        order_id;
    logic               side;
    logic               order_type;
    logic signed [31:0] price;
    logic [31:0]        quantity;
  } order_t;

  typedef struct packed {
    logic               kind;
    logic [63:0]        buy_id;
    logic signed [31:0] buy_price;
    logic [63:0]        sell_id;
    logic signed [31:0] sell_price;
    logic [31:0]        fill_qty;
    status_t            status;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/lobm_if.sv
// Interfaces: valid/ready channels for orders and result records.
`default_nettype none
interface lobm_order_if;
  logic              valid;
  logic              ready;
  lobm_pkg::order_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lobm_result_if;
  logic              valid;
  logic              ready;
  lobm_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/limit_order_book_matcher_unit.sv
// Top level: price-time priority limit order book with a sequential matcher.
// Each pass sweeps every book slot through the single read port; an order takes one pass,
// plus one pass per trade, then a rest step if it rests and a closing status record.
// A new order is accepted only once the previous order's status record has been loaded.
// Reset (rst, synchronous): empties the book, clears the arrival counter and
// drops any pending record; slot contents are left as they are.
`default_nettype none
module limit_order_book_matcher_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  lobm_order_if.sink    in_ch,
  lobm_result_if.source out_ch
);

  localparam int N  = lobm_pkg::BOOK_SLOTS;
  localparam int IW = lobm_pkg::SLOT_W;
  localparam int CW = lobm_pkg::CNT_W;

  lobm_pkg::state_t state, state_next;

  // Book storage: valid bits in flops, slot contents in memories.
  logic [N-1:0]        slot_valid;
  logic [63:0]         mem_id     [N];
  logic                mem_side   [N];
  logic signed [31:0]  mem_price  [N];
  logic [31:0]         mem_rem    [N];
  logic [31:0]         mem_arr    [N];
  logic [31:0]         arrival_counter;

  // Latched incoming order and its running remainder.
  lobm_pkg::order_t    ord;
  logic [31:0]         remaining;
  logic [CW-1:0]       trades;
  logic                first_pass;

  // Scan pipeline: address stage, then registered read data.
  logic [CW-1:0]       rd_idx;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic [63:0]         rd_id;
  logic                rd_side;
  logic signed [31:0]  rd_price;
  logic [31:0]         rd_rem;
  logic [31:0]         rd_arr;

  // Scan results.
  logic                dup;
  logic                free_found;
  logic [IW-1:0]       free_idx;
  logic                best_found;
  logic [IW-1:0]       best_idx;
  logic [63:0]         best_id;
  logic signed [31:0]  best_price;
  logic [31:0]         best_rem;
  logic [31:0]         best_age;

  // Output register.
  logic                out_valid;
  lobm_pkg::result_t   res;
  logic                out_free;

  // Control from the sequencer.
  logic                in_take;
  logic                scan_init;
  logic                trade_go;
  logic                rest_go;
  logic                status_go;
  lobm_pkg::status_t   status_code;

  // Decision terms shared by the next-state and output logic.
  logic                scan_done;
  logic                crosses;
  logic                more_fill;
  logic                will_rest;
  logic [31:0]         fill_q;
  logic [31:0]         cur_age;
  logic                better;

  assign out_free  = !out_valid || out_ch.ready;
  assign scan_done = cmp_vld && (cmp_idx == IW'(N - 1));
  assign crosses   = best_found && ((ord.side == lobm_pkg::SIDE_BUY) ?
                     (ord.price >= best_price) : (ord.price <= best_price));
  assign more_fill = (remaining != '0) && (trades < CW'(N)) && crosses;
  assign will_rest = (ord.order_type != lobm_pkg::TYPE_FAK) && (remaining != '0) && free_found;
  assign fill_q    = (remaining < best_rem) ? remaining : best_rem;
  assign cur_age   = arrival_counter - rd_arr;

  // One compare unit, reused for every slot of the sweep.
  always_comb begin
    if (!best_found) begin
      better = 1'b1;
    end else if (ord.side == lobm_pkg::SIDE_BUY) begin
      better = (rd_price < best_price) || ((rd_price == best_price) && (cur_age > best_age));
    end else begin
      better = (rd_price > best_price) || ((rd_price == best_price) && (cur_age > best_age));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lobm_pkg::S_IDLE:   if (in_ch.valid) state_next = lobm_pkg::S_SCAN;
      lobm_pkg::S_SCAN:   if (scan_done) state_next = lobm_pkg::S_DECIDE;
      lobm_pkg::S_DECIDE: begin
        if (first_pass && (dup || ((ord.order_type == lobm_pkg::TYPE_FAK) && !crosses)
                           || !free_found)) begin
          state_next = lobm_pkg::S_STATUS;
        end else if (more_fill) begin
          state_next = lobm_pkg::S_TRADE;
        end else if (will_rest) begin
          state_next = lobm_pkg::S_REST;
        end else begin
          state_next = lobm_pkg::S_STATUS;
        end
      end
      lobm_pkg::S_TRADE:  if (out_free) state_next = lobm_pkg::S_SCAN;
      lobm_pkg::S_REST:   state_next = lobm_pkg::S_STATUS;
      lobm_pkg::S_STATUS: if (out_free) state_next = lobm_pkg::S_IDLE;
      default:            state_next = lobm_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_take   = 1'b0;
    scan_init = 1'b0;
    trade_go  = 1'b0;
    rest_go   = 1'b0;
    status_go = 1'b0;
    unique case (state)
      lobm_pkg::S_IDLE: begin
        in_take   = in_ch.valid;
        scan_init = in_ch.valid;
      end
      lobm_pkg::S_TRADE: begin
        trade_go  = out_free;
        scan_init = out_free;
      end
      lobm_pkg::S_REST:   rest_go   = 1'b1;
      lobm_pkg::S_STATUS: status_go = out_free;
      default: ;
    endcase
    if (!first_pass) begin
      status_code = lobm_pkg::ST_ACCEPTED;
    end else if (dup) begin
      status_code = lobm_pkg::ST_DUPLICATE;
    end else if ((ord.order_type == lobm_pkg::TYPE_FAK) && !crosses) begin
      status_code = lobm_pkg::ST_NO_CROSS;
    end else if (!free_found) begin
      status_code = lobm_pkg::ST_FULL;
    end else begin
      status_code = lobm_pkg::ST_ACCEPTED;
    end
  end

  // Status of a pass that went on to matching is always accepted.
  logic status_first;
  always_ff @(posedge clk) begin
    if (rst) begin
      status_first <= 1'b0;
    end else if (state == lobm_pkg::S_DECIDE) begin
      status_first <= first_pass;
    end
  end

  assign in_ch.ready = (state == lobm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lobm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Book memories: one read address per cycle, written by trades and rests.
  always_ff @(posedge clk) begin
    rd_id    <= mem_id[rd_idx[IW-1:0]];
    rd_side  <= mem_side[rd_idx[IW-1:0]];
    rd_price <= mem_price[rd_idx[IW-1:0]];
    rd_arr   <= mem_arr[rd_idx[IW-1:0]];
    if (rest_go) begin
      mem_id[free_idx]    <= ord.order_id;
      mem_side[free_idx]  <= ord.side;
      mem_price[free_idx] <= ord.price;
      mem_arr[free_idx]   <= arrival_counter;
    end
  end

  always_ff @(posedge clk) begin
    rd_rem <= mem_rem[rd_idx[IW-1:0]];
    if (rest_go) begin
      mem_rem[free_idx] <= remaining;
    end else if (trade_go) begin
      mem_rem[best_idx] <= best_rem - fill_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      arrival_counter <= '0;
    end else if (rest_go) begin
      slot_valid[free_idx] <= 1'b1;
      arrival_counter      <= arrival_counter + 32'd1;
    end else if (trade_go && (fill_q == best_rem)) begin
      slot_valid[best_idx] <= 1'b0;
    end
  end

  // Order latch, remainder and trade count.
  always_ff @(posedge clk) begin
    if (rst) begin
      trades     <= '0;
      first_pass <= 1'b0;
    end else if (in_take) begin
      ord        <= in_ch.data;
      remaining  <= in_ch.data.quantity;
      trades     <= '0;
      first_pass <= 1'b1;
    end else if (trade_go) begin
      remaining  <= remaining - fill_q;
      trades     <= trades + CW'(1);
      first_pass <= 1'b0;
    end
  end

  // Sweep the book: address stage, then evaluate each slot in turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (scan_init) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (state == lobm_pkg::S_SCAN && rd_idx < CW'(N)) begin
      rd_idx  <= rd_idx + CW'(1);
      cmp_vld <= 1'b1;
      cmp_idx <= rd_idx[IW-1:0];
    end else begin
      cmp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_init) begin
      dup        <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (cmp_vld) begin
      if (slot_valid[cmp_idx] && (rd_id == ord.order_id)) dup <= 1'b1;
      if (!slot_valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (slot_valid[cmp_idx] && (rd_side != ord.side) && better) begin
        best_found <= 1'b1;
        best_idx   <= cmp_idx;
        best_id    <= rd_id;
        best_price <= rd_price;
        best_rem   <= rd_rem;
        best_age   <= cur_age;
      end
    end
  end

  // Output register: load a trade or the closing status record.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (trade_go || status_go) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (trade_go) begin
      res.kind     <= lobm_pkg::KIND_TRADE;
      res.fill_qty <= fill_q;
      res.status   <= lobm_pkg::ST_ACCEPTED;
      res.last     <= 1'b0;
      if (ord.side == lobm_pkg::SIDE_BUY) begin
        res.buy_id     <= ord.order_id;
        res.buy_price  <= ord.price;
        res.sell_id    <= best_id;
        res.sell_price <= best_price;
      end else begin
        res.buy_id     <= best_id;
        res.buy_price  <= best_price;
        res.sell_id    <= ord.order_id;
        res.sell_price <= ord.price;
      end
    end else if (status_go) begin
      res.kind       <= lobm_pkg::KIND_STATUS;
      res.buy_id     <= '0;
      res.buy_price  <= '0;
      res.sell_id    <= '0;
      res.sell_price <= '0;
      res.fill_qty   <= '0;
      res.status     <= status_first ? status_code : lobm_pkg::ST_ACCEPTED;
      res.last       <= 1'b1;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (trade_go || status_go) |-> (!out_valid || out_ch.ready))
    else $error("record loaded over a pending transfer");
  a_trade_bound: assert property (@(posedge clk) disable iff (rst)
    trades <= CW'(N))
    else $error("more trades than book slots for one order");
  a_trade_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.kind == lobm_pkg::KIND_TRADE) |-> !res.last)
    else $error("trade record marked last");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (slot_valid == '0 && !out_valid))
    else $error("book not empty after reset");
`endif

endmodule
`default_nettype wire
